FILE: rtl/two_level_page_table_manager_macros.svh
// assertion macros used by the page table manager checker
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define TLPT_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TLPT_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/tlpt_pkg.sv
// types, sizes and codes of the two-level page table manager
package tlpt_pkg;

   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;

   localparam int FRAME_W = 20;
   localparam int FLAGS_W = 12;
   localparam int ENTRY_W = FRAME_W + FLAGS_W;
   localparam int INDEX_W = 10;

   localparam int DIR_W        = $clog2(DIR_ENTRIES);
   localparam int TAB_W        = $clog2(TABLE_ENTRIES);
   localparam int SLOT_ENTRIES = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int SLOT_W       = $clog2(SLOT_ENTRIES);

   // index reduction by reciprocal multiply with one correction step
   localparam int RECIP_SH = 2 * INDEX_W;
   localparam int RECIP_W  = RECIP_SH;
   localparam int PROD_W   = INDEX_W + RECIP_W;
   localparam int REM_W    = INDEX_W + 1;
   localparam logic [RECIP_W-1:0] DIR_RECIP = RECIP_W'((1 << RECIP_SH) / DIR_ENTRIES);
   localparam logic [RECIP_W-1:0] TAB_RECIP = RECIP_W'((1 << RECIP_SH) / TABLE_ENTRIES);

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_ALREADY    = 2'd1;
   localparam logic [1:0] STAT_NOT_MAPPED = 2'd2;
   localparam logic [1:0] STAT_NO_FRAME   = 2'd3;

   localparam logic [FLAGS_W-1:0] ENTRY_PRESENT = 12'h001;
   localparam logic [FLAGS_W-1:0] ENTRY_RW      = 12'h002;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [FRAME_W-1:0] virt_page;
      logic [FRAME_W-1:0] map_frame;
      logic [FLAGS_W-1:0] entry_flags;
      logic               release_frame;
      logic [FRAME_W-1:0] spare_frame;
      logic               spare_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FRAME_W-1:0] result_frame;
      logic               mapped;
      logic               frame_to_free;
      logic               spare_taken;
   } rsp_type;

endpackage

FILE: rtl/tlpt_ram.sv
// single-port synchronous ram with registered read data
module tlpt_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/two_level_page_table_manager.sv
// two-level page table manager: map, unmap and query over directory and table rams
// results: the strobe follows the directory check when the directory entry decides, the table
// read when the table entry is read, and the table fill when map builds a new table
// throughput: one item at a time, start is taken again in the cycle of the strobe
// reset: busy while the directory ram is swept to not present
// the receiver cannot stall: each result is strobed for one cycle only
module two_level_page_table_manager (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tlpt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tlpt_pkg::rsp_type rsp_data
);
   import tlpt_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_QUOT,
      S_REM,
      S_DIR,
      S_DIRCHK,
      S_TAB,
      S_FILL
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [INDEX_W-1:0]  q_dir_ff, q_dir_in;
   logic [INDEX_W-1:0]  q_tab_ff, q_tab_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [TAB_W-1:0]    tab_ff, tab_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic [DIR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [TAB_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                dir_we;
   logic [DIR_W-1:0]    dir_addr;
   logic [ENTRY_W-1:0]  dir_wdata;
   logic [ENTRY_W-1:0]  dir_rdata;
   logic                tab_we;
   logic [SLOT_W-1:0]   tab_addr;
   logic [ENTRY_W-1:0]  tab_wdata;
   logic [ENTRY_W-1:0]  tab_rdata;

   tlpt_ram #(.DEPTH(DIR_ENTRIES), .WIDTH(ENTRY_W)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .addr    (dir_addr),
      .wr_data (dir_wdata),
      .rd_data (dir_rdata)
   );

   tlpt_ram #(.DEPTH(SLOT_ENTRIES), .WIDTH(ENTRY_W)) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .addr    (tab_addr),
      .wr_data (tab_wdata),
      .rd_data (tab_rdata)
   );

   always_comb begin
      logic [PROD_W-1:0]  dir_prod;
      logic [PROD_W-1:0]  tab_prod;
      logic [REM_W-1:0]   dir_rem;
      logic [REM_W-1:0]   tab_rem;
      logic [SLOT_W-1:0]  slot;
      logic [ENTRY_W-1:0] new_entry;
      rsp_type            resp;
      logic               finish;

      state_in      = state_ff;
      req_in        = req_ff;
      q_dir_in      = q_dir_ff;
      q_tab_in      = q_tab_ff;
      dir_in        = dir_ff;
      tab_in        = tab_ff;
      base_in       = base_ff;
      clr_cnt_in    = clr_cnt_ff;
      fill_cnt_in   = fill_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      dir_prod  = PROD_W'(req_ff.virt_page[2*INDEX_W-1:INDEX_W]) * PROD_W'(DIR_RECIP);
      tab_prod  = PROD_W'(req_ff.virt_page[INDEX_W-1:0]) * PROD_W'(TAB_RECIP);
      dir_rem   = REM_W'(req_ff.virt_page[2*INDEX_W-1:INDEX_W])
                  - REM_W'(REM_W'(q_dir_ff) * REM_W'(DIR_ENTRIES));
      tab_rem   = REM_W'(req_ff.virt_page[INDEX_W-1:0])
                  - REM_W'(REM_W'(q_tab_ff) * REM_W'(TABLE_ENTRIES));
      if (dir_rem >= REM_W'(DIR_ENTRIES)) begin
         dir_rem = dir_rem - REM_W'(DIR_ENTRIES);
      end
      if (tab_rem >= REM_W'(TABLE_ENTRIES)) begin
         tab_rem = tab_rem - REM_W'(TABLE_ENTRIES);
      end
      slot      = base_ff + SLOT_W'(tab_ff);
      new_entry = {req_ff.map_frame, req_ff.entry_flags | ENTRY_PRESENT};
      resp      = '0;
      finish    = 1'b0;

      dir_we    = 1'b0;
      dir_addr  = dir_ff;
      dir_wdata = '0;
      tab_we    = 1'b0;
      tab_addr  = slot;
      tab_wdata = '0;

      unique case (state_ff)
         S_CLEAR: begin
            dir_we     = 1'b1;
            dir_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == DIR_W'(DIR_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            q_dir_in = dir_prod[PROD_W-1:RECIP_SH];
            q_tab_in = tab_prod[PROD_W-1:RECIP_SH];
            state_in = S_REM;
         end
         S_REM: begin
            dir_in   = DIR_W'(dir_rem);
            tab_in   = TAB_W'(tab_rem);
            state_in = S_DIR;
         end
         S_DIR: begin
            base_in  = SLOT_W'(dir_ff) * SLOT_W'(TABLE_ENTRIES);
            state_in = S_DIRCHK;
         end
         S_DIRCHK: begin
            unique case (req_ff.opcode)
               OP_MAP: begin
                  if (dir_rdata[0]) begin
                     state_in = S_TAB;
                  end else if (req_ff.spare_valid) begin
                     dir_we      = 1'b1;
                     dir_wdata   = {req_ff.spare_frame, ENTRY_RW | ENTRY_PRESENT};
                     fill_cnt_in = '0;
                     state_in    = S_FILL;
                  end else begin
                     resp.status = STAT_NO_FRAME;
                     finish      = 1'b1;
                  end
               end
               OP_UNMAP: begin
                  if (dir_rdata[0]) begin
                     state_in = S_TAB;
                  end else begin
                     resp.status = STAT_NOT_MAPPED;
                     finish      = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (dir_rdata[0]) begin
                     state_in = S_TAB;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         S_TAB: begin
            unique case (req_ff.opcode)
               OP_MAP: begin
                  if (tab_rdata[0]) begin
                     resp.status = STAT_ALREADY;
                  end else begin
                     tab_we    = 1'b1;
                     tab_wdata = new_entry;
                  end
               end
               OP_UNMAP: begin
                  if (tab_rdata[0]) begin
                     tab_we             = 1'b1;
                     resp.result_frame  = tab_rdata[ENTRY_W-1:FLAGS_W];
                     resp.frame_to_free = req_ff.release_frame
                                          && (tab_rdata[ENTRY_W-1:FLAGS_W] != '0);
                  end else begin
                     resp.status = STAT_NOT_MAPPED;
                  end
               end
               default: begin
                  if (tab_rdata[0]) begin
                     resp.mapped       = 1'b1;
                     resp.result_frame = tab_rdata[ENTRY_W-1:FLAGS_W];
                  end
               end
            endcase
            finish = 1'b1;
         end
         S_FILL: begin
            tab_we      = 1'b1;
            tab_addr    = base_ff + SLOT_W'(fill_cnt_ff);
            tab_wdata   = (fill_cnt_ff == tab_ff) ? new_entry : '0;
            fill_cnt_in = fill_cnt_ff + 1'b1;
            if (fill_cnt_ff == TAB_W'(TABLE_ENTRIES - 1)) begin
               resp.spare_taken = 1'b1;
               finish           = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_strobe_in = 1'b1;
         rsp_data_in   = resp;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      q_dir_ff    <= q_dir_in;
      q_tab_ff    <= q_tab_in;
      dir_ff      <= dir_in;
      tab_ff      <= tab_in;
      base_ff     <= base_in;
      fill_cnt_ff <= fill_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: rtl/tlpt_checker.sv
// port-level checks of the page table manager, bound to the top level
`include "two_level_page_table_manager_macros.svh"

module tlpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input tlpt_pkg::rsp_type rsp_data
);
   import tlpt_pkg::*;

   `TLPT_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy && !rsp_strobe, "transfer accepted but block not busy")
   `TLPT_ASSERT_NXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `TLPT_ASSERT_IMP(a_strobe_when_idle, rsp_strobe, !busy, "result shown while still busy")
   `TLPT_ASSERT_IMP(a_taken_is_ok, rsp_strobe && rsp_data.spare_taken, (rsp_data.status == STAT_OK) && !rsp_data.mapped, "spare taken on a failed map")
   `TLPT_ASSERT_IMP(a_free_has_frame, rsp_strobe && rsp_data.frame_to_free, (rsp_data.result_frame != '0) && (rsp_data.status == STAT_OK), "frame to free without a frame")

endmodule

bind two_level_page_table_manager tlpt_checker u_tlpt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
